>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/tftp_rx_pkg.sv
package tftp_rx_pkg;

    // event kinds
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_PACKET = 2'd1;
    localparam logic [1:0] FUNC_TIMER = 2'd2;

    // tftp opcodes
    localparam logic [15:0] OPC_DATA = 16'd3;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    // result actions
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_REQUEST = 3'd1;
    localparam logic [2:0] ACT_ACK = 3'd2;
    localparam logic [2:0] ACT_ERROR = 3'd3;
    localparam logic [2:0] ACT_BAD_OPCODE = 3'd4;
    localparam logic [2:0] ACT_RESEND = 3'd5;

    // error kinds
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_INVALID_BLOCK = 3'd1;
    localparam logic [2:0] ERR_INVALID_STATE = 3'd2;
    localparam logic [2:0] ERR_INVALID_PORT = 3'd3;
    localparam logic [2:0] ERR_UNEXPECTED_BLOCK = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_SRC_PORT_BASE = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd1;

    // reset values of the configuration registers
    localparam logic [15:0] SRC_PORT_BASE_RESET = 16'd1024;
    localparam logic [10:0] BLOCK_SIZE_RESET = 11'd512;

    // the request port cycle spans base .. base + 256
    localparam logic [16:0] PORT_CYCLE_SPAN = 17'd256;

    // low nibble pattern that raises the activity tick
    localparam logic [3:0] TICK_NIBBLE = 4'hf;

    typedef struct packed {
        logic [1:0] func;
        logic [15:0] opcode;
        logic [15:0] block_num;
        logic [15:0] peer_port;
        logic [10:0] payload_len;
        logic [31:0] load_addr;
        logic [15:0] peer_err_code;
        logic give_up;
    } in_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [15:0] ack_block;
        logic [2:0] error_kind;
        logic write_enable;
        logic [31:0] write_addr;
        logic [10:0] write_len;
        logic [2:0] xfer_state;
        logic [31:0] total_bytes;
        logic total_valid;
        logic [15:0] request_port;
        logic activity_tick;
        logic [15:0] peer_error;
    } out_item_t;

endpackage

>>> rtl/tftp_client_receive_fsm.sv
// channel | direction | handshake               | payload
// in      | input     | in_valid / in_ready     | in_data   (tftp_rx_pkg::in_item_t)
// out     | output    | out_valid / out_ready   | out_data  (tftp_rx_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one event per cycle: the decision is a single pass of logic on the transfer
// registers and the incoming event, landing in the result register in the
// cycle after the transfer in. the result register is the only stall point: a
// new event is taken whenever the result register is empty or being drained.
// cfg writes never stall (cfg_ready is high). rst_n clears transfer state,
// config registers (to 1024 / 512) and the result valid; no clearing pass.
module tftp_client_receive_fsm #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tftp_rx_pkg::in_item_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tftp_rx_pkg::out_item_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import tftp_rx_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SENT    = 3'd1,
        ST_ACTIVE  = 3'd2,
        ST_ERROR   = 3'd3,
        ST_TIMEOUT = 3'd4
    } state_t;

    // configuration
    logic [15:0] src_port_base_reg;
    logic [10:0] block_size_reg;

    // transfer state
    state_t                  state_reg, state_next;
    logic [15:0]             prev_block_reg, prev_block_next;
    logic [15:0]             server_port_reg, server_port_next;
    logic [ADDR_WIDTH-1:0]   next_addr_reg, next_addr_next;
    logic [31:0]             byte_total_reg, byte_total_next;
    logic                    byte_total_ok_reg, byte_total_ok_next;
    logic [15:0]             local_port_reg, local_port_next;
    logic                    last_was_request_reg, last_was_request_next;

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic        in_fire;
    logic [15:0] port_advanced;
    logic        go;
    logic [15:0] prev_eff;
    logic [15:0] server_eff;

    // terms watched by the checks at the end
    logic        out_write;
    logic        out_err_kind;
    logic        start_fire;
    logic        start_seen;

    // result register drains or is empty: take the next event
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next request port in the cycle, 17-bit compare so base + 256 never wraps
    assign port_advanced = ({1'b0, local_port_reg} < ({1'b0, src_port_base_reg} + PORT_CYCLE_SPAN))
                           ? local_port_reg + 16'd1 : src_port_base_reg;

    always_comb
    begin
        state_next            = state_reg;
        prev_block_next       = prev_block_reg;
        server_port_next      = server_port_reg;
        next_addr_next        = next_addr_reg;
        byte_total_next       = byte_total_reg;
        byte_total_ok_next    = byte_total_ok_reg;
        local_port_next       = local_port_reg;
        last_was_request_next = last_was_request_reg;
        out_data_next         = '0;
        go                    = 1'b0;
        prev_eff              = prev_block_reg;
        server_eff            = server_port_reg;

        case (in_data.func)
            FUNC_START:
            begin
                state_next                 = ST_SENT;
                next_addr_next             = ADDR_WIDTH'(in_data.load_addr);
                byte_total_next            = 32'd0;
                byte_total_ok_next         = 1'b1;
                local_port_next            = port_advanced;
                last_was_request_next      = 1'b1;
                out_data_next.request_port = port_advanced;
                out_data_next.action       = ACT_REQUEST;
            end
            FUNC_TIMER:
            begin
                if (state_reg == ST_SENT || state_reg == ST_ACTIVE)
                begin
                    if (in_data.give_up)
                    begin
                        state_next = ST_TIMEOUT;
                    end
                    else
                    begin
                        out_data_next.action = ACT_RESEND;
                        if (last_was_request_reg)
                        begin
                            local_port_next            = port_advanced;
                            out_data_next.request_port = port_advanced;
                        end
                    end
                end
            end
            FUNC_PACKET:
            begin
                if (in_data.opcode == OPC_DATA)
                begin
                    // first data block after a request locks the server port
                    if (state_reg == ST_SENT)
                    begin
                        prev_eff        = 16'd0;
                        prev_block_next = 16'd0;
                        if (in_data.block_num == 16'd1)
                        begin
                            server_eff       = in_data.peer_port;
                            server_port_next = in_data.peer_port;
                            state_next       = ST_ACTIVE;
                            go               = 1'b1;
                        end
                        else
                        begin
                            state_next               = ST_ERROR;
                            out_data_next.action     = ACT_ERROR;
                            out_data_next.error_kind = ERR_INVALID_BLOCK;
                        end
                    end
                    else if (state_reg == ST_IDLE && in_data.block_num == prev_block_reg)
                    begin
                        // late duplicate of the final block
                        out_data_next.action    = ACT_ACK;
                        out_data_next.ack_block = in_data.block_num;
                    end
                    else if (state_reg != ST_ACTIVE)
                    begin
                        state_next               = ST_ERROR;
                        out_data_next.action     = ACT_ERROR;
                        out_data_next.error_kind = ERR_INVALID_STATE;
                    end
                    else
                    begin
                        go = 1'b1;
                    end

                    if (go)
                    begin
                        if (in_data.peer_port != server_eff)
                        begin
                            out_data_next.action     = ACT_ERROR;
                            out_data_next.error_kind = ERR_INVALID_PORT;
                        end
                        else if (in_data.block_num == prev_eff)
                        begin
                            out_data_next.action    = ACT_ACK;
                            out_data_next.ack_block = in_data.block_num;
                        end
                        else if ({1'b0, in_data.block_num} != ({1'b0, prev_eff} + 17'd1))
                        begin
                            state_next               = ST_ERROR;
                            byte_total_ok_next       = 1'b0;
                            out_data_next.action     = ACT_ERROR;
                            out_data_next.error_kind = ERR_UNEXPECTED_BLOCK;
                        end
                        else
                        begin
                            byte_total_next = byte_total_reg + 32'(in_data.payload_len);
                            prev_block_next = in_data.block_num;
                            // short block ends the transfer
                            if (in_data.payload_len < block_size_reg)
                            begin
                                state_next = ST_IDLE;
                            end
                            next_addr_next = next_addr_reg + ADDR_WIDTH'(in_data.payload_len);
                            out_data_next.write_enable  = 1'b1;
                            out_data_next.write_addr    = 32'(next_addr_reg);
                            out_data_next.write_len     = in_data.payload_len;
                            out_data_next.activity_tick =
                                (in_data.block_num[3:0] == TICK_NIBBLE);
                            out_data_next.action    = ACT_ACK;
                            out_data_next.ack_block = in_data.block_num;
                        end
                    end
                    last_was_request_next = 1'b0;
                end
                else if (in_data.opcode == OPC_ERROR)
                begin
                    byte_total_ok_next       = 1'b0;
                    state_next               = ST_ERROR;
                    out_data_next.peer_error = in_data.peer_err_code;
                end
                else
                begin
                    byte_total_ok_next   = 1'b0;
                    out_data_next.action = ACT_BAD_OPCODE;
                end
            end
            default:
            begin
                // unused event code: no change
            end
        endcase

        out_data_next.xfer_state  = 3'(state_next);
        out_data_next.total_bytes = byte_total_next;
        out_data_next.total_valid = byte_total_ok_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_port_base_reg <= SRC_PORT_BASE_RESET;
            block_size_reg    <= BLOCK_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SRC_PORT_BASE: src_port_base_reg <= cfg_data;
                CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data[10:0];
                default:
                begin
                    // index beyond the register list: ignored
                end
            endcase
        end
    end

    // transfer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            prev_block_reg       <= 16'd0;
            server_port_reg      <= 16'd0;
            next_addr_reg        <= '0;
            byte_total_reg       <= 32'd0;
            byte_total_ok_reg    <= 1'b0;
            local_port_reg       <= SRC_PORT_BASE_RESET;
            last_was_request_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg            <= state_next;
                prev_block_reg       <= prev_block_next;
                server_port_reg      <= server_port_next;
                next_addr_reg        <= next_addr_next;
                byte_total_reg       <= byte_total_next;
                byte_total_ok_reg    <= byte_total_ok_next;
                local_port_reg       <= local_port_next;
                last_was_request_reg <= last_was_request_next;
                out_valid_reg        <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each transfer in
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_write    = out_valid && out_data.write_enable;
    assign out_err_kind = out_valid && (out_data.error_kind != ERR_NONE);
    assign start_fire   = in_fire && (in_data.func == FUNC_START);
    assign start_seen   = out_valid && (out_data.action == ACT_REQUEST) && (state_reg == ST_SENT);

    // a payload write is always acknowledged
    `ASSERT_IMPL(a_write_acks, clk, rst_n, out_write, out_data.action == ACT_ACK)
    // an error kind only travels with a send-error action
    `ASSERT_IMPL(a_err_kind_action, clk, rst_n, out_err_kind, out_data.action == ACT_ERROR)
    // a start always yields a request and moves to request sent
    `ASSERT_NEXT(a_start_request, clk, rst_n, start_fire, start_seen)

endmodule
